/* rtl/mdm_pkg.sv */
// ----------------------------------------------------------------------------
// mdm_pkg
// Shared types and constants of the row-wise dense matrix multiplier.
// ----------------------------------------------------------------------------
package mdm_pkg;

  localparam int DEF_MAX_DIM = 16;
  localparam int SIZE_W      = 5;
  localparam int SIZE_RST    = 16;
  localparam int CMD_W       = 2;
  localparam int IDX_PORT_W  = 4;
  localparam int ELEM_W      = 32;
  localparam int SUM_W       = 64;
  // wide enough for any index, any size and the largest supported dimension
  localparam int CMP_W       = 7;
  localparam int K_W         = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_A = 2'd0,
    CMD_WR_B = 2'd1,
    CMD_ROW  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FEED,
    ST_WAIT,
    ST_OUT
  } state_e;

  // element write broadcast to the column cells
  typedef struct packed {
    logic                  we;
    logic [IDX_PORT_W-1:0] row;
    logic [IDX_PORT_W-1:0] col;
    logic [ELEM_W-1:0]     data;
  } mdm_wr_t;

  // one A element travelling along the cell chain
  typedef struct packed {
    logic                     vld;
    logic                     first;
    logic                     last;
    logic [K_W-1:0]           k;
    logic signed [ELEM_W-1:0] a;
  } mdm_tok_t;

  // finished column sum, shifted toward cell 0 for readout
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             sat;
  } mdm_res_t;

endpackage

/* rtl/mdm_cell.sv */
// ----------------------------------------------------------------------------
// mdm_cell
// One column of C: holds its column of B, multiplies the passing A elements
// and accumulates exactly, then saturates and joins the readout shift chain.
// ----------------------------------------------------------------------------
module mdm_cell #(
  parameter int MAX_DIM  = mdm_pkg::DEF_MAX_DIM,
  parameter int CELL_IDX = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mdm_pkg::mdm_wr_t  wr_i,
  input  mdm_pkg::mdm_tok_t tok_i,
  output mdm_pkg::mdm_tok_t tok_o,
  input  logic              shift_i,
  input  mdm_pkg::mdm_res_t res_i,
  output mdm_pkg::mdm_res_t res_o,
  output logic              done_o
);

  localparam int IDX_W = $clog2(MAX_DIM);
  localparam int ACC_W = mdm_pkg::SUM_W + $clog2(MAX_DIM);
  localparam int HI_W  = ACC_W - mdm_pkg::SUM_W + 1;

  logic [mdm_pkg::ELEM_W-1:0] bmem [MAX_DIM];

  logic                              b_we;
  logic signed [mdm_pkg::ELEM_W-1:0] b_q;
  logic signed [mdm_pkg::ELEM_W-1:0] a1_q;
  logic                              v1_q, first1_q, last1_q;
  logic signed [mdm_pkg::SUM_W-1:0]  prod_q;
  logic                              v2_q, first2_q, last2_q;
  logic signed [ACC_W-1:0]           acc_q;
  logic                              fin_q;
  logic                              done_q;
  mdm_pkg::mdm_tok_t                 tok_q;
  mdm_pkg::mdm_res_t                 res_q;
  mdm_pkg::mdm_res_t                 sat_res;
  logic [HI_W-1:0]                   hi_bits;
  logic                              ovf;

  assign b_we = wr_i.we &&
                (mdm_pkg::CMP_W'(wr_i.col) == mdm_pkg::CMP_W'(CELL_IDX));

  // B column store, registered read
  always_ff @(posedge clk_i) begin
    if (b_we) begin
      bmem[IDX_W'(wr_i.row)] <= wr_i.data;
    end
    if (tok_i.vld) begin
      b_q  <= bmem[tok_i.k[IDX_W-1:0]];
      a1_q <= tok_i.a;
    end
    if (v1_q) begin
      prod_q <= a1_q * b_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q    <= '0;
      v1_q     <= 1'b0;
      first1_q <= 1'b0;
      last1_q  <= 1'b0;
      v2_q     <= 1'b0;
      first2_q <= 1'b0;
      last2_q  <= 1'b0;
      fin_q    <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      tok_q    <= tok_i;
      v1_q     <= tok_i.vld;
      first1_q <= tok_i.vld && tok_i.first;
      last1_q  <= tok_i.vld && tok_i.last;
      v2_q     <= v1_q;
      first2_q <= first1_q;
      last2_q  <= last1_q;
      fin_q    <= v2_q && last2_q;
      done_q   <= fin_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      if (first2_q) begin
        acc_q <= ACC_W'(prod_q);
      end else begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
  end

  // clip the exact sum to the signed 64-bit range
  always_comb begin
    hi_bits     = acc_q[ACC_W-1:mdm_pkg::SUM_W-1];
    ovf         = !((&hi_bits) || !(|hi_bits));
    sat_res.sat = ovf;
    if (!ovf) begin
      sat_res.sum = acc_q[mdm_pkg::SUM_W-1:0];
    end else if (acc_q[ACC_W-1]) begin
      sat_res.sum = {1'b1, {(mdm_pkg::SUM_W-1){1'b0}}};
    end else begin
      sat_res.sum = {1'b0, {(mdm_pkg::SUM_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_q) begin
      res_q <= sat_res;
    end else if (shift_i) begin
      res_q <= res_i;
    end
  end

  assign tok_o  = tok_q;
  assign res_o  = res_q;
  assign done_o = done_q;

endmodule

/* rtl/mdm_feed.sv */
// ----------------------------------------------------------------------------
// mdm_feed
// Request sequencer: takes element writes, keeps the A store, streams one
// row of A into the cell chain and steps the column readout.
// ----------------------------------------------------------------------------
module mdm_feed #(
  parameter int MAX_DIM = mdm_pkg::DEF_MAX_DIM,
  parameter int DIM_W   = $clog2(MAX_DIM + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [DIM_W-1:0]                   n_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [mdm_pkg::CMD_W-1:0]          cmd_i,
  input  logic [mdm_pkg::IDX_PORT_W-1:0]     row_i,
  input  logic [mdm_pkg::IDX_PORT_W-1:0]     col_i,
  input  logic signed [mdm_pkg::ELEM_W-1:0]  value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [mdm_pkg::IDX_PORT_W-1:0]     out_row_o,
  output logic [mdm_pkg::IDX_PORT_W-1:0]     out_col_o,
  output logic                               out_last_o,
  output mdm_pkg::mdm_wr_t                   wr_o,
  output mdm_pkg::mdm_tok_t                  tok_o,
  output logic                               shift_o,
  input  logic                               done_i
);

  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);

  logic [mdm_pkg::ELEM_W-1:0] amem [MAX_DIM*MAX_DIM];

  mdm_pkg::state_e state_q, state_d;

  logic [mdm_pkg::IDX_PORT_W-1:0] row_q;
  logic [IDX_W-1:0]               k_q, col_q;
  logic [mdm_pkg::ELEM_W-1:0]     amem_q;
  logic                           tv_q, tf_q, tl_q;
  logic [IDX_W-1:0]               tk_q;

  logic              accept, in_range, row_ok, a_we;
  logic              issue, k_last, col_last;
  logic [ADDR_W-1:0] wr_addr, rd_addr;

  assign accept   = in_valid_i && in_ready_o;
  assign in_range = (mdm_pkg::CMP_W'(row_i) < mdm_pkg::CMP_W'(MAX_DIM)) &&
                    (mdm_pkg::CMP_W'(col_i) < mdm_pkg::CMP_W'(MAX_DIM));
  assign row_ok   = mdm_pkg::CMP_W'(row_i) < mdm_pkg::CMP_W'(n_i);
  assign k_last   = DIM_W'(k_q) == (n_i - DIM_W'(1));
  assign col_last = DIM_W'(col_q) == (n_i - DIM_W'(1));
  assign wr_addr  = ADDR_W'(row_i) * ADDR_W'(MAX_DIM) + ADDR_W'(col_i);
  assign rd_addr  = ADDR_W'(row_q) * ADDR_W'(MAX_DIM) + ADDR_W'(k_q);
  assign a_we     = accept && in_range && (cmd_i == mdm_pkg::CMD_WR_A);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mdm_pkg::ST_IDLE: begin
        if (in_valid_i && (cmd_i == mdm_pkg::CMD_ROW) && row_ok) begin
          state_d = mdm_pkg::ST_FEED;
        end
      end
      mdm_pkg::ST_FEED: begin
        if (k_last) begin
          state_d = mdm_pkg::ST_WAIT;
        end
      end
      mdm_pkg::ST_WAIT: begin
        if (done_i) begin
          state_d = mdm_pkg::ST_OUT;
        end
      end
      mdm_pkg::ST_OUT: begin
        if (out_ready_i && col_last) begin
          state_d = mdm_pkg::ST_IDLE;
        end
      end
      default: state_d = mdm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == mdm_pkg::ST_IDLE);
    out_valid_o = (state_q == mdm_pkg::ST_OUT);
    issue       = (state_q == mdm_pkg::ST_FEED);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mdm_pkg::ST_IDLE;
      row_q   <= '0;
      k_q     <= '0;
      col_q   <= '0;
      tv_q    <= 1'b0;
      tf_q    <= 1'b0;
      tl_q    <= 1'b0;
      tk_q    <= '0;
    end else begin
      state_q <= state_d;
      tv_q    <= issue;
      tf_q    <= issue && (k_q == '0);
      tl_q    <= issue && k_last;
      tk_q    <= k_q;
      if (accept && (cmd_i == mdm_pkg::CMD_ROW)) begin
        row_q <= row_i;
        k_q   <= '0;
        col_q <= '0;
      end
      if (issue) begin
        k_q <= k_q + IDX_W'(1);
      end
      // advance readout on each taken result
      if (out_valid_o && out_ready_i) begin
        col_q <= col_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      amem[wr_addr] <= value_i;
    end
    if (issue) begin
      amem_q <= amem[rd_addr];
    end
  end

  always_comb begin
    wr_o.we   = accept && in_range && (cmd_i == mdm_pkg::CMD_WR_B);
    wr_o.row  = row_i;
    wr_o.col  = col_i;
    wr_o.data = value_i;
    tok_o.vld   = tv_q;
    tok_o.first = tf_q;
    tok_o.last  = tl_q;
    tok_o.k     = mdm_pkg::K_W'(tk_q);
    tok_o.a     = amem_q;
  end

  assign shift_o    = out_valid_o && out_ready_i;
  assign out_row_o  = row_q;
  assign out_col_o  = mdm_pkg::IDX_PORT_W'(col_q);
  assign out_last_o = col_last;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("request and result side open together");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> (state_q == mdm_pkg::ST_WAIT))
    else $error("chain finished outside the wait phase");

  a_tok_after_feed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tv_q |-> $past(state_q == mdm_pkg::ST_FEED))
    else $error("A element issued outside the feed phase");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_last_o) |=> in_ready_o)
    else $error("block not free after final column");

endmodule

/* rtl/dense_matrix_multiply_rows_top.sv */
// ----------------------------------------------------------------------------
// dense_matrix_multiply_rows_top
// Row-at-a-time C = A x B over Q16.16 elements, Q32.32 saturated sums.
//
//   channel  direction  handshake                 payload
//   in       to block   in_valid_i / in_ready_o   cmd_i row_i col_i value_i
//   out      from block out_valid_o / out_ready_i out_row_o out_col_o
//                                                 product_sum_o saturated_o last_o
//   cfg      to block   cfg_valid_i / cfg_ready_o cfg_data_i (matrix size)
//
// An element write is taken whenever the block is idle. A row request of size
// n streams row A through the chain of MAX_DIM column cells: n A elements are
// fed in, then the cells finish their sums, then n results are offered, one per
// cycle while out_ready_i is high. No request is taken until the last result
// of a row is taken; a stalled output holds the block in readout.
// Reset sets the size to 16; both element stores are not cleared.
// ----------------------------------------------------------------------------
module dense_matrix_multiply_rows_top #(
  parameter int MAX_DIM = mdm_pkg::DEF_MAX_DIM
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [mdm_pkg::SIZE_W-1:0]             cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [mdm_pkg::CMD_W-1:0]              cmd_i,
  input  logic [mdm_pkg::IDX_PORT_W-1:0]         row_i,
  input  logic [mdm_pkg::IDX_PORT_W-1:0]         col_i,
  input  logic signed [mdm_pkg::ELEM_W-1:0]      value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [mdm_pkg::IDX_PORT_W-1:0]         out_row_o,
  output logic [mdm_pkg::IDX_PORT_W-1:0]         out_col_o,
  output logic signed [mdm_pkg::SUM_W-1:0]       product_sum_o,
  output logic                                   saturated_o,
  output logic                                   last_o
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);

  logic [mdm_pkg::SIZE_W-1:0] size_q;
  logic [mdm_pkg::CMP_W-1:0]  size_ext, eff_n;
  logic [DIM_W-1:0]           n;

  mdm_pkg::mdm_wr_t  wr;
  mdm_pkg::mdm_tok_t tok_w [MAX_DIM+1];
  mdm_pkg::mdm_res_t res_w [MAX_DIM+1];
  logic [MAX_DIM-1:0] done_w;
  logic               shift;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= mdm_pkg::SIZE_W'(mdm_pkg::SIZE_RST);
    end else if (cfg_valid_i && cfg_ready_o) begin
      size_q <= cfg_data_i;
    end
  end

  // zero counts as one, anything above the array counts as the array
  always_comb begin
    size_ext = mdm_pkg::CMP_W'(size_q);
    priority if (size_ext == '0) begin
      eff_n = mdm_pkg::CMP_W'(1);
    end else if (size_ext > mdm_pkg::CMP_W'(MAX_DIM)) begin
      eff_n = mdm_pkg::CMP_W'(MAX_DIM);
    end else begin
      eff_n = size_ext;
    end
    n = DIM_W'(eff_n);
  end

  mdm_feed #(
    .MAX_DIM (MAX_DIM),
    .DIM_W   (DIM_W)
  ) u_feed (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_i         (n),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .out_last_o  (last_o),
    .wr_o        (wr),
    .tok_o       (tok_w[0]),
    .shift_o     (shift),
    .done_i      (done_w[MAX_DIM-1])
  );

  assign res_w[MAX_DIM] = '0;

  for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
    mdm_cell #(
      .MAX_DIM  (MAX_DIM),
      .CELL_IDX (j)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .wr_i    (wr),
      .tok_i   (tok_w[j]),
      .tok_o   (tok_w[j+1]),
      .shift_i (shift),
      .res_i   (res_w[j+1]),
      .res_o   (res_w[j]),
      .done_o  (done_w[j])
    );
  end

  assign product_sum_o = res_w[0].sum;
  assign saturated_o   = res_w[0].sat;

  // each cell finishes in the cycle after the one before it, so never two at once
  a_done_skew: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(done_w))
    else $error("two cells finished in the same cycle");

endmodule

/* test/dense_matrix_multiply_rows_top_test.sv */
// ----------------------------------------------------------------------------
// dense_matrix_multiply_rows_top_test
// Self-checking bench for the row-wise matrix multiplier. Element writes and
// row requests go in over the request channel; every C element that comes
// back is compared against a software copy of both element stores and the
// size register. A short directed pass covers value extremes, saturation in
// both directions, the unused command, out-of-range rows and size clamping.
// A random pass follows, with random stalls on both channels.
// ----------------------------------------------------------------------------
module dense_matrix_multiply_rows_top_test;

  localparam int MAX_DIM     = mdm_pkg::DEF_MAX_DIM;
  localparam int DRAIN       = 64;
  localparam int STALL_LIMIT = 2000;
  localparam logic [mdm_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [71:0] SUM_HI = 72'sh00_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [71:0] SUM_LO = 72'shFF_8000_0000_0000_0000;

  typedef struct packed {
    logic [mdm_pkg::IDX_PORT_W-1:0] row;
    logic [mdm_pkg::IDX_PORT_W-1:0] col;
    logic [mdm_pkg::SUM_W-1:0]      sum;
    logic                           sat;
    logic                           last;
  } c_elem_t;

  class row_product_board;
    logic [mdm_pkg::ELEM_W-1:0] a_store [MAX_DIM*MAX_DIM];
    logic [mdm_pkg::ELEM_W-1:0] b_store [MAX_DIM*MAX_DIM];
    logic [mdm_pkg::SIZE_W-1:0] size_reg;
    c_elem_t                    c_elems_due [$];
    int                         errors;

    function new();
      size_reg = mdm_pkg::SIZE_W'(mdm_pkg::SIZE_RST);
      errors   = 0;
      foreach (a_store[i]) begin
        a_store[i] = '0;
        b_store[i] = '0;
      end
    endfunction

    function void set_size(logic [mdm_pkg::SIZE_W-1:0] sz);
      size_reg = sz;
    endfunction

    // zero counts as one, anything past the array dimension counts as the max
    function int eff_size();
      if (size_reg == 0) return 1;
      if (size_reg > MAX_DIM) return MAX_DIM;
      return size_reg;
    endfunction

    function int pending();
      return c_elems_due.size();
    endfunction

    function void note_request(logic [mdm_pkg::CMD_W-1:0] cmd,
                               logic [mdm_pkg::IDX_PORT_W-1:0] r,
                               logic [mdm_pkg::IDX_PORT_W-1:0] c,
                               logic [mdm_pkg::ELEM_W-1:0] v);
      int                 n;
      logic signed [71:0] acc;
      logic signed [71:0] ax;
      logic signed [71:0] bx;
      c_elem_t            e;
      if (cmd == mdm_pkg::CMD_WR_A) begin
        a_store[r*MAX_DIM+c] = v;
      end else if (cmd == mdm_pkg::CMD_WR_B) begin
        b_store[r*MAX_DIM+c] = v;
      end else if (cmd == mdm_pkg::CMD_ROW) begin
        n = eff_size();
        if (r < n) begin
          for (int j = 0; j < n; j++) begin
            acc = '0;
            for (int k = 0; k < n; k++) begin
              ax  = $signed(a_store[r*MAX_DIM+k]);
              bx  = $signed(b_store[k*MAX_DIM+j]);
              acc = acc + ax * bx;
            end
            // clip only once the exact sum is known
            if (acc > SUM_HI) begin
              e.sum = SUM_HI[63:0];
              e.sat = 1'b1;
            end else if (acc < SUM_LO) begin
              e.sum = SUM_LO[63:0];
              e.sat = 1'b1;
            end else begin
              e.sum = acc[63:0];
              e.sat = 1'b0;
            end
            e.row  = r;
            e.col  = 4'(j);
            e.last = (j == n - 1);
            c_elems_due.push_back(e);
          end
        end
      end
    endfunction

    function void check_element(logic [mdm_pkg::IDX_PORT_W-1:0] r,
                                logic [mdm_pkg::IDX_PORT_W-1:0] c,
                                logic [mdm_pkg::SUM_W-1:0] sum, logic sat, logic last);
      c_elem_t want;
      if (c_elems_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected C element: row %0d col %0d sum %h sat %b last %b",
                   r, c, sum, sat, last);
      end else begin
        want = c_elems_due.pop_front();
        if (want.row !== r || want.col !== c || want.sum !== sum || want.sat !== sat ||
            want.last !== last) begin
          errors++;
          if (errors <= 10) begin
            $display("C element mismatch: expected row %0d col %0d sum %h sat %b last %b",
                     want.row, want.col, want.sum, want.sat, want.last);
            $display("  got row %0d col %0d sum %h sat %b last %b",
                     r, c, sum, sat, last);
          end
        end
      end
    endfunction
  endclass

  logic                                  clk_i       = 1'b0;
  logic                                  rst_ni      = 1'b0;
  logic                                  cfg_valid_i = 1'b0;
  logic                                  cfg_ready_o;
  logic [mdm_pkg::SIZE_W-1:0]            cfg_data_i  = '0;
  logic                                  in_valid_i  = 1'b0;
  logic                                  in_ready_o;
  logic [mdm_pkg::CMD_W-1:0]             cmd_i       = '0;
  logic [mdm_pkg::IDX_PORT_W-1:0]        row_i       = '0;
  logic [mdm_pkg::IDX_PORT_W-1:0]        col_i       = '0;
  logic signed [mdm_pkg::ELEM_W-1:0]     value_i     = '0;
  logic                                  out_valid_o;
  logic                                  out_ready_i = 1'b0;
  logic [mdm_pkg::IDX_PORT_W-1:0]        out_row_o;
  logic [mdm_pkg::IDX_PORT_W-1:0]        out_col_o;
  logic signed [mdm_pkg::SUM_W-1:0]      product_sum_o;
  logic                                  saturated_o;
  logic                                  last_o;

  row_product_board sb;
  bit               a_written [MAX_DIM*MAX_DIM];
  bit               b_written [MAX_DIM*MAX_DIM];
  bit               steady      = 1'b0;
  int               quiet_cycles = 0;

  dense_matrix_multiply_rows_top #(
    .MAX_DIM(MAX_DIM)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .product_sum_o(product_sum_o),
    .saturated_o  (saturated_o),
    .last_o       (last_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 29);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_element(out_row_o, out_col_o, product_sum_o, saturated_o, last_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [mdm_pkg::ELEM_W-1:0] rand_elem();
    int s;
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: begin
        // within +-2.0 in Q16.16
        s = $urandom_range(262143) - 131072;
        return s;
      end
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [mdm_pkg::IDX_PORT_W-1:0] near_index(int n);
    return ($urandom_range(99) < 80) ? 4'($urandom_range(n)) : 4'($urandom_range(15));
  endfunction

  task automatic send(input logic [mdm_pkg::CMD_W-1:0] cmd,
                      input logic [mdm_pkg::IDX_PORT_W-1:0] r,
                      input logic [mdm_pkg::IDX_PORT_W-1:0] c,
                      input logic [mdm_pkg::ELEM_W-1:0] v);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(99) < 29) gap = $urandom_range(4, 1);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    row_i      <= r;
    col_i      <= c;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(cmd, r, c, v);
    if (cmd == mdm_pkg::CMD_WR_A) a_written[r*MAX_DIM+c] = 1'b1;
    if (cmd == mdm_pkg::CMD_WR_B) b_written[r*MAX_DIM+c] = 1'b1;
  endtask

  // drop valid and hold until every C element due has come back
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_size(input logic [mdm_pkg::SIZE_W-1:0] sz);
    settle();
    repeat (DRAIN) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= sz;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_size(sz);
  endtask

  // write whatever the row product would read before it was written, then ask
  task automatic ask_row(input logic [mdm_pkg::IDX_PORT_W-1:0] r);
    int n;
    n = sb.eff_size();
    if (r < n) begin
      for (int k = 0; k < n; k++)
        if (!a_written[r*MAX_DIM+k]) send(mdm_pkg::CMD_WR_A, r, 4'(k), rand_elem());
      for (int k = 0; k < n; k++)
        for (int c = 0; c < n; c++)
          if (!b_written[k*MAX_DIM+c])
            send(mdm_pkg::CMD_WR_B, 4'(k), 4'(c), rand_elem());
    end
    send(mdm_pkg::CMD_ROW, r, 4'($urandom_range(15)), $urandom);
  endtask

  task automatic run_phase(input logic [mdm_pkg::SIZE_W-1:0] sz, input int count,
                           input bit hold_mid);
    int n;
    int pick;
    write_size(sz);
    n = sb.eff_size();
    for (int i = 0; i < count; i++) begin
      if (hold_mid && i == count / 2) settle();
      pick = $urandom_range(99);
      if (pick < 45)
        send(mdm_pkg::CMD_WR_A, near_index(n), near_index(n), rand_elem());
      else if (pick < 80)
        send(mdm_pkg::CMD_WR_B, near_index(n), near_index(n), rand_elem());
      else if (pick < 95)
        ask_row(($urandom_range(99) < 85) ? 4'($urandom_range(n - 1)) :
                                            4'($urandom_range(15)));
      else
        send(CMD_UNUSED, 4'($urandom_range(15)), 4'($urandom_range(15)), $urandom);
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // size zero behaves as one
    write_size(5'd0);
    send(mdm_pkg::CMD_WR_A, 4'd0, 4'd0, 32'h7FFF_FFFF);
    send(mdm_pkg::CMD_WR_B, 4'd0, 4'd0, 32'h8000_0000);
    send(CMD_UNUSED, 4'd0, 4'd0, 32'hFFFF_FFFF);
    ask_row(4'd0);
    send(mdm_pkg::CMD_ROW, 4'd1, 4'd15, 32'h0);
    send(mdm_pkg::CMD_WR_A, 4'd15, 4'd15, 32'hFFFF_FFFF);

    // column 0 clips high, column 1 clips low, column 2 stays in range
    write_size(5'd3);
    for (int k = 0; k < 3; k++) send(mdm_pkg::CMD_WR_A, 4'd0, 4'(k), 32'h8000_0000);
    for (int k = 0; k < 3; k++) begin
      send(mdm_pkg::CMD_WR_B, 4'(k), 4'd0, 32'h8000_0000);
      send(mdm_pkg::CMD_WR_B, 4'(k), 4'd1, 32'h7FFF_FFFF);
      send(mdm_pkg::CMD_WR_B, 4'(k), 4'd2, 32'h0001_0000);
    end
    ask_row(4'd0);
    ask_row(4'd2);

    run_phase(5'd2, 6, 1'b0);
    run_phase(5'd1, 4, 1'b1);
    steady = 1'b1;
    run_phase(5'd5, 6, 1'b0);
    steady = 1'b0;
    run_phase(5'd4, 4, 1'b0);
    run_phase(5'd0, 2, 1'b0);
    run_phase(5'd3, 4, 1'b0);
    run_phase(5'($urandom_range(6, 2)), 4, 1'b0);

    // full size: fills the whole right store once
    write_size(5'd16);
    steady = 1'b1;
    ask_row(4'd15);
    steady = 1'b0;
    ask_row(4'd0);
    repeat (8) send(($urandom_range(1) != 0) ? mdm_pkg::CMD_WR_B : mdm_pkg::CMD_WR_A,
                    4'($urandom_range(15)), 4'($urandom_range(15)), rand_elem());
    ask_row(4'd15);

    // above the array dimension clamps to it
    write_size(5'd31);
    ask_row(4'd15);
    repeat (6) send(mdm_pkg::CMD_WR_B, 4'($urandom_range(15)), 4'($urandom_range(15)),
                    rand_elem());
    ask_row(4'd0);

    run_phase(5'd2, 2, 1'b0);

    settle();
    repeat (DRAIN) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
